### hw/rtl/assert_macros.svh
// Assertion macros used by the tokenizer RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### hw/rtl/cst_pkg.sv
// Package for the C subset tokenizer: payload structs, scan modes, token codes.
// Depends on nothing; imported by cst_scan and c_subset_tokenizer_unit.
package cst_pkg;

  localparam int KeywordChars = 8;
  localparam int LineBits = 24;
  localparam logic [15:0] LenMax = 16'hFFFF;

  localparam logic [5:0] KindIdent = 6'd16;
  localparam logic [5:0] KindConst = 6'd17;
  localparam logic [5:0] KindEnd = 6'd18;
  localparam logic [5:0] KindPunct = 6'd19;

  localparam logic [1:0] ErrNone = 2'd0;
  localparam logic [1:0] ErrUnknown = 2'd1;
  localparam logic [1:0] ErrLetterDigit = 2'd2;

  typedef enum logic [3:0] {
    M_START, M_IDENT, M_NUMBER, M_SLASH, M_LINECMT,
    M_BLOCKCMT, M_BLOCKSTAR, M_OP, M_ERROR
  } scan_mode_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [1:0]  error_code;
    logic [31:0] start_offset;
    logic [15:0] token_length;
    logic [23:0] line_number;
    logic        run_last;
  } out_item_t;

  // Punctuator code from its index in the punctuator list.
  function automatic logic [5:0] punct(input logic [5:0] idx);
    return KindPunct + idx;
  endfunction

  // Keyword code for a window of up to eight characters, or identifier.
  function automatic logic [5:0] kw_lookup(input logic [8*KeywordChars-1:0] w,
                                           input logic [15:0] len);
    logic [63:0] s;
    logic [5:0] k;
    s = w[63:0];
    k = KindIdent;
    // Window holds first character in the low byte.
    case (len)
      16'd2: begin
        if (s[15:0] == {"f","i"}) k = 6'd3;
        if (s[15:0] == {"o","d"}) k = 6'd10;
      end
      16'd3: begin
        if (s[23:0] == {"t","n","i"}) k = 6'd0;
        if (s[23:0] == {"r","o","f"}) k = 6'd8;
      end
      16'd4: begin
        if (s[31:0] == {"d","i","o","v"}) k = 6'd2;
        if (s[31:0] == {"e","s","l","e"}) k = 6'd4;
        if (s[31:0] == {"o","t","o","g"}) k = 6'd5;
        if (s[31:0] == {"e","s","a","c"}) k = 6'd12;
      end
      16'd5: begin
        if (s[39:0] == {"k","a","e","r","b"}) k = 6'd6;
        if (s[39:0] == {"e","l","i","h","w"}) k = 6'd9;
      end
      16'd6: begin
        if (s[47:0] == {"n","r","u","t","e","r"}) k = 6'd1;
        if (s[47:0] == {"h","c","t","i","w","s"}) k = 6'd11;
        if (s[47:0] == {"n","r","e","t","x","e"}) k = 6'd14;
        if (s[47:0] == {"c","i","t","a","t","s"}) k = 6'd15;
      end
      16'd7: begin
        if (s[55:0] == {"t","l","u","a","f","e","d"}) k = 6'd13;
      end
      16'd8: begin
        if (s == {"e","u","n","i","t","n","o","c"}) k = 6'd7;
      end
      default: k = KindIdent;
    endcase
    return k;
  endfunction

endpackage

### hw/rtl/cst_scan.sv
// Combinational scan step of the tokenizer: next state and up to two tokens.
// Depends on cst_pkg.
module cst_scan import cst_pkg::*; (
  input  in_item_t    item,
  input  scan_mode_t  mode,
  input  logic [7:0]  pend_op,
  input  logic [1:0]  op_stage,
  input  logic [63:0] kw_win,
  input  logic [15:0] run_len,
  input  logic [31:0] run_start,
  input  logic [31:0] byte_off,
  input  logic [23:0] line_cnt,
  output scan_mode_t  mode_nxt,
  output logic [7:0]  pend_op_nxt,
  output logic [1:0]  op_stage_nxt,
  output logic [63:0] kw_win_nxt,
  output logic [15:0] run_len_nxt,
  output logic [31:0] run_start_nxt,
  output logic [31:0] byte_off_nxt,
  output logic [23:0] line_cnt_nxt,
  output logic [1:0]  tok_cnt,
  output out_item_t   tok0,
  output out_item_t   tok1
);

  logic [7:0] c;
  logic is_dig, is_alp, line_up, fresh_go;
  logic [15:0] len_inc;
  logic [5:0] pair_code, single_code;
  out_item_t t0, t1;
  logic [1:0] n;

  assign c = item.byte_value;
  assign is_dig = (c >= "0") && (c <= "9");
  assign is_alp = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  assign len_inc = (run_len == LenMax) ? run_len : run_len + 16'd1;

  // Single and paired operator codes for the pending operator.
  always_comb begin
    case (pend_op)
      "+": single_code = punct(6'd5);
      "-": single_code = punct(6'd8);
      "*": single_code = punct(6'd11);
      "%": single_code = punct(6'd13);
      "&": single_code = punct(6'd18);
      "|": single_code = punct(6'd21);
      "^": single_code = punct(6'd24);
      "!": single_code = punct(6'd26);
      "<": single_code = punct(6'd28);
      ">": single_code = punct(6'd32);
      default: single_code = punct(6'd36);
    endcase
    pair_code = 6'd0;
    if (c == "=") begin
      case (pend_op)
        "+": pair_code = punct(6'd7);
        "-": pair_code = punct(6'd10);
        "*": pair_code = punct(6'd12);
        "%": pair_code = punct(6'd14);
        "&": pair_code = punct(6'd20);
        "|": pair_code = punct(6'd23);
        "^": pair_code = punct(6'd25);
        "!": pair_code = punct(6'd27);
        "<": pair_code = punct(6'd31);
        ">": pair_code = punct(6'd35);
        "=": pair_code = punct(6'd37);
        default: pair_code = 6'd0;
      endcase
    end else if (c == pend_op) begin
      case (pend_op)
        "+": pair_code = punct(6'd6);
        "-": pair_code = punct(6'd9);
        "&": pair_code = punct(6'd19);
        "|": pair_code = punct(6'd22);
        default: pair_code = 6'd0;
      endcase
    end
  end

  // Main step: first token from the pending run, second from a fresh start or the end marker.
  always_comb begin
    logic [5:0] k0, k1;
    logic [1:0] e0, e1;
    logic [31:0] s0, s1;
    logic [15:0] l0, l1;
    logic [23:0] ln;
    logic e_tok0, e_tok1;
    mode_nxt = mode;
    pend_op_nxt = pend_op;
    op_stage_nxt = op_stage;
    kw_win_nxt = kw_win;
    run_len_nxt = run_len;
    run_start_nxt = run_start;
    byte_off_nxt = byte_off + 32'd1;
    line_up = 1'b0;
    fresh_go = 1'b0;
    e_tok0 = 1'b0; e_tok1 = 1'b0;
    k0 = '0; e0 = ErrNone; s0 = run_start; l0 = run_len;
    k1 = '0; e1 = ErrNone; s1 = byte_off; l1 = 16'd1;
    if (item.end_of_input) begin
      case (mode)
        M_IDENT: begin
          e_tok0 = 1'b1;
          k0 = (run_len <= 16'(KeywordChars)) ? kw_lookup(kw_win, run_len) : KindIdent;
        end
        M_NUMBER: begin e_tok0 = 1'b1; k0 = KindConst; end
        M_SLASH: begin e_tok0 = 1'b1; k0 = punct(6'd15); l0 = 16'd1; end
        M_OP: begin
          e_tok0 = 1'b1;
          if (op_stage == 2'd2) begin
            k0 = (pend_op == "<") ? punct(6'd29) : punct(6'd33); l0 = 16'd2;
          end else begin
            k0 = single_code; l0 = 16'd1;
          end
        end
        default: ;
      endcase
      e_tok1 = 1'b1; k1 = KindEnd; s1 = byte_off; l1 = 16'd0;
      mode_nxt = M_START; pend_op_nxt = '0; op_stage_nxt = '0; kw_win_nxt = '0;
      run_len_nxt = '0; run_start_nxt = '0; byte_off_nxt = '0;
    end else begin
      case (mode)
        M_IDENT: begin
          if (is_alp || is_dig || c == "_") begin
            if (run_len < 16'(KeywordChars)) kw_win_nxt[run_len[2:0]*8 +: 8] = c;
            run_len_nxt = len_inc;
          end else begin
            e_tok0 = 1'b1;
            k0 = (run_len <= 16'(KeywordChars)) ? kw_lookup(kw_win, run_len) : KindIdent;
            fresh_go = 1'b1;
          end
        end
        M_NUMBER: begin
          if (is_dig) run_len_nxt = len_inc;
          else if (is_alp) begin
            run_len_nxt = len_inc;
            e_tok0 = 1'b1; k0 = 6'd0; e0 = ErrLetterDigit; l0 = len_inc;
            mode_nxt = M_ERROR;
          end else begin
            e_tok0 = 1'b1; k0 = KindConst; fresh_go = 1'b1;
          end
        end
        M_SLASH: begin
          if (c == "/") mode_nxt = M_LINECMT;
          else if (c == "*") mode_nxt = M_BLOCKCMT;
          else if (c == "=") begin
            e_tok0 = 1'b1; k0 = punct(6'd16); l0 = 16'd2; mode_nxt = M_START;
          end else begin
            e_tok0 = 1'b1; k0 = punct(6'd15); l0 = 16'd1; fresh_go = 1'b1;
          end
        end
        M_LINECMT: if (c == 8'h0A) begin line_up = 1'b1; mode_nxt = M_START; end
        M_BLOCKCMT: begin
          if (c == "*") mode_nxt = M_BLOCKSTAR;
          else if (c == 8'h0A) line_up = 1'b1;
        end
        M_BLOCKSTAR: begin
          if (c == "/") mode_nxt = M_START;
          else if (c != "*") begin
            line_up = (c == 8'h0A);
            mode_nxt = M_BLOCKCMT;
          end
        end
        M_OP: begin
          if (op_stage == 2'd2) begin
            if (c == "=") begin
              e_tok0 = 1'b1; l0 = 16'd3; mode_nxt = M_START;
              k0 = (pend_op == "<") ? punct(6'd30) : punct(6'd34);
            end else begin
              e_tok0 = 1'b1; l0 = 16'd2; fresh_go = 1'b1;
              k0 = (pend_op == "<") ? punct(6'd29) : punct(6'd33);
            end
          end else if ((pend_op == "<" || pend_op == ">") && c == pend_op) begin
            op_stage_nxt = 2'd2;
          end else if (pair_code != 6'd0) begin
            e_tok0 = 1'b1; k0 = pair_code; l0 = 16'd2; mode_nxt = M_START;
          end else begin
            e_tok0 = 1'b1; k0 = single_code; l0 = 16'd1; fresh_go = 1'b1;
          end
        end
        M_ERROR: ;
        default: fresh_go = 1'b1;
      endcase
      // Start a new token from this byte.
      if (fresh_go) begin
        mode_nxt = M_START;
        case (c)
          " ", 8'h09, 8'h0D: ;
          8'h0A: line_up = 1'b1;
          "/": begin mode_nxt = M_SLASH; run_start_nxt = byte_off; end
          "(": begin e_tok1 = 1'b1; k1 = punct(6'd0); end
          ")": begin e_tok1 = 1'b1; k1 = punct(6'd1); end
          "{": begin e_tok1 = 1'b1; k1 = punct(6'd2); end
          "}": begin e_tok1 = 1'b1; k1 = punct(6'd3); end
          ";": begin e_tok1 = 1'b1; k1 = punct(6'd4); end
          "~": begin e_tok1 = 1'b1; k1 = punct(6'd17); end
          "?": begin e_tok1 = 1'b1; k1 = punct(6'd38); end
          ":": begin e_tok1 = 1'b1; k1 = punct(6'd39); end
          ",": begin e_tok1 = 1'b1; k1 = punct(6'd40); end
          "+", "-", "*", "%", "&", "|", "^", "!", "<", ">", "=": begin
            mode_nxt = M_OP; pend_op_nxt = c; op_stage_nxt = 2'd1;
            run_start_nxt = byte_off;
          end
          default: begin
            if (is_dig) begin
              mode_nxt = M_NUMBER; run_start_nxt = byte_off; run_len_nxt = 16'd1;
            end else if (is_alp || c == "_") begin
              mode_nxt = M_IDENT; run_start_nxt = byte_off; run_len_nxt = 16'd1;
              kw_win_nxt = {56'd0, c};
            end else begin
              e_tok1 = 1'b1; k1 = 6'd0; e1 = ErrUnknown; mode_nxt = M_ERROR;
            end
          end
        endcase
      end
    end
    // Line count saturates; the second token carries the updated count, the first the old one.
    ln = (line_up && line_cnt != {LineBits{1'b1}}) ? line_cnt + 24'd1 : line_cnt;
    line_cnt_nxt = item.end_of_input ? '0 : ln;
    t0 = '{token_kind: k0, error_code: e0, start_offset: s0, token_length: l0,
           line_number: line_cnt, run_last: 1'b0};
    t1 = '{token_kind: k1, error_code: e1, start_offset: s1, token_length: l1,
           line_number: ln, run_last: 1'b1};
    // Pack present tokens to the front.
    n = {1'b0, e_tok0} + {1'b0, e_tok1};
    tok_cnt = n;
    if (e_tok0) begin
      tok0 = t0;
      tok0.run_last = !e_tok1;
      tok1 = t1;
    end else begin
      tok0 = t1;
      tok1 = t1;
    end
  end

endmodule

### hw/rtl/c_subset_tokenizer_unit.sv
// C subset tokenizer: one source byte in per request, tokens out.
// Channel in_ carries a source byte or an end marker; out_ carries tokens.
// Latency: the first token caused by a request is offered the cycle after acceptance.
// Throughput: one request per cycle while each request yields at most one
// token and the receiver takes every token; a request that yields two
// tokens holds the second in a skid slot, and input waits until that slot
// is empty again. Each token carries kind, error code, start offset, length,
// line number and run_last marking the final token of its request.
// Reset (rst_n low, synchronous) returns the scanner to the start mode at
// offset 0, line 0, and drops any queued tokens.
// A stalled receiver holds out_item stable; input stops while the skid slot
// is full or the output register holds a token that is not being taken.
// End of input flushes any pending token, emits the end token, and starts
// a new source at offset 0.
`include "assert_macros.svh"
module c_subset_tokenizer_unit import cst_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  scan_mode_t  mode_r, mode_nxt;
  logic [7:0]  pend_op_r, pend_op_nxt;
  logic [1:0]  op_stage_r, op_stage_nxt;
  logic [63:0] kw_win_r, kw_win_nxt;
  logic [15:0] run_len_r, run_len_nxt;
  logic [31:0] run_start_r, run_start_nxt;
  logic [31:0] byte_off_r, byte_off_nxt;
  logic [23:0] line_cnt_r, line_cnt_nxt;
  logic [1:0]  tok_cnt;
  out_item_t   tok0, tok1;
  out_item_t   out_r, skid_r;
  logic        out_vld_r, skid_vld_r;
  logic        acc, pop;

  cst_scan u_scan (
    .item(in_item), .mode(mode_r), .pend_op(pend_op_r), .op_stage(op_stage_r),
    .kw_win(kw_win_r), .run_len(run_len_r), .run_start(run_start_r),
    .byte_off(byte_off_r), .line_cnt(line_cnt_r),
    .mode_nxt(mode_nxt), .pend_op_nxt(pend_op_nxt), .op_stage_nxt(op_stage_nxt),
    .kw_win_nxt(kw_win_nxt), .run_len_nxt(run_len_nxt),
    .run_start_nxt(run_start_nxt), .byte_off_nxt(byte_off_nxt),
    .line_cnt_nxt(line_cnt_nxt), .tok_cnt(tok_cnt), .tok0(tok0), .tok1(tok1)
  );

  // Accept when the skid slot is empty and the output slot is empty or frees this cycle.
  assign pop = out_vld_r && out_ready;
  assign in_ready = !skid_vld_r && (!out_vld_r || out_ready);
  assign acc = in_valid && in_ready;
  assign out_valid = out_vld_r;
  assign out_item = out_r;

  // Advance scanner state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_START;
      pend_op_r <= '0;
      op_stage_r <= '0;
      kw_win_r <= '0;
      run_len_r <= '0;
      run_start_r <= '0;
      byte_off_r <= '0;
      line_cnt_r <= '0;
    end else if (acc) begin
      mode_r <= mode_nxt;
      pend_op_r <= pend_op_nxt;
      op_stage_r <= op_stage_nxt;
      kw_win_r <= kw_win_nxt;
      run_len_r <= run_len_nxt;
      run_start_r <= run_start_nxt;
      byte_off_r <= byte_off_nxt;
      line_cnt_r <= line_cnt_nxt;
    end
  end

  // Load output and skid slots.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (acc) begin
      out_vld_r <= (tok_cnt != 2'd0);
      skid_vld_r <= (tok_cnt == 2'd2);
      out_r <= tok0;
      skid_r <= tok1;
    end else if (pop) begin
      out_vld_r <= skid_vld_r;
      skid_vld_r <= 1'b0;
      out_r <= skid_r;
    end
  end

  `ASSERT_IMP(a_skid_needs_out, clk, rst_n, skid_vld_r, out_vld_r)
  `ASSERT_IMP(a_no_acc_with_skid, clk, rst_n, skid_vld_r, !in_ready)
  `ASSERT_NXT(a_end_resets_offset, clk, rst_n, acc && in_item.end_of_input,
              byte_off_r == 32'd0 && mode_r == M_START)

endmodule
